// File: rtl/core/fbfp_pkg.sv
// ----------------------------------------------------------------------------
// fbfp_pkg
// Shared types and codes of the flagged binary frame parser.
// ----------------------------------------------------------------------------
package fbfp_pkg;

    typedef enum logic [3:0] {
        PH_CMD    = 4'd0,
        PH_PARAM  = 4'd1,
        PH_SLEN   = 4'd2,
        PH_SBYTE  = 4'd3,
        PH_ICNT   = 4'd4,
        PH_SCNT   = 4'd5,
        PH_AINT   = 4'd6,
        PH_ASLEN  = 4'd7,
        PH_ASBYTE = 4'd8
    } phase_t;

    localparam logic [3:0] KIND_CMD     = 4'd0;
    localparam logic [3:0] KIND_PARAM   = 4'd1;
    localparam logic [3:0] KIND_SLEN    = 4'd2;
    localparam logic [3:0] KIND_SBYTE   = 4'd3;
    localparam logic [3:0] KIND_ICNT    = 4'd4;
    localparam logic [3:0] KIND_SCNT    = 4'd5;
    localparam logic [3:0] KIND_AINT    = 4'd6;
    localparam logic [3:0] KIND_ASLEN   = 4'd7;
    localparam logic [3:0] KIND_ASBYTE  = 4'd8;

    localparam int FLAG_STR = 0;
    localparam int FLAG_INT = 1;
    localparam int FLAG_EXT = 2;
    localparam int FLAG_ARR = 3;

    localparam int QUEUE_DEPTH = 2;

    // one result travelling from the parser to the output side
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [31:0] index;
        logic        frame_end;
    } result_t;

endpackage

// File: rtl/core/fbfp_front.sv
// ----------------------------------------------------------------------------
// fbfp_front
// Takes one byte per cycle, assembles words and tracks the frame layout.
// ----------------------------------------------------------------------------
module fbfp_front
    import fbfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_valid,
    input  logic [7:0]  byte_data,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  bpos_reg, bpos_next;
    logic [23:0] shift_reg, shift_next;
    logic [3:0]  flags_reg, flags_next;
    logic [31:0] ints_reg, ints_next;
    logic [31:0] strs_reg, strs_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [31:0] elem_reg, elem_next;
    logic [31:0] boff_reg, boff_next;

    always_comb begin
        logic [31:0] w;
        logic [31:0] bdec;
        logic [31:0] sdec;
        logic [1:0]  pidx;
        w          = {shift_reg, byte_data};
        bdec       = (bytes_reg != 32'd0) ? bytes_reg - 32'd1 : 32'd0;
        sdec       = (strs_reg != 32'd0) ? strs_reg - 32'd1 : 32'd0;
        pidx       = elem_reg[1:0];
        phase_next = phase_reg;
        bpos_next  = bpos_reg;
        shift_next = shift_reg;
        flags_next = flags_reg;
        ints_next  = ints_reg;
        strs_next  = strs_reg;
        bytes_next = bytes_reg;
        elem_next  = elem_reg;
        boff_next  = boff_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (byte_valid) begin
            if (phase_reg == PH_SBYTE || phase_reg == PH_ASBYTE) begin
                res_valid  = 1'b1;
                res.kind   = (phase_reg == PH_SBYTE) ? KIND_SBYTE : KIND_ASBYTE;
                res.value  = {24'd0, byte_data};
                res.index  = boff_reg;
                boff_next  = boff_reg + 32'd1;
                bytes_next = bdec;
                if (bdec == 32'd0) begin
                    boff_next = '0;
                    if (phase_reg == PH_SBYTE || sdec == 32'd0) begin
                        strs_next     = sdec;
                        if (phase_reg == PH_SBYTE) strs_next = strs_reg;
                        res.frame_end = 1'b1;
                        phase_next    = PH_CMD;
                        elem_next     = '0;
                    end else begin
                        strs_next  = sdec;
                        elem_next  = elem_reg + 32'd1;
                        phase_next = PH_ASLEN;
                    end
                end
            end else if (bpos_reg != 2'd3) begin
                shift_next = {shift_reg[15:0], byte_data};
                bpos_next  = bpos_reg + 2'd1;
            end else begin
                bpos_next  = '0;
                shift_next = '0;
                res_valid  = 1'b1;
                res.value  = w;
                case (phase_reg)
                    PH_CMD: begin
                        res.kind   = KIND_CMD;
                        flags_next = w[31:28];
                        elem_next  = '0;
                        boff_next  = '0;
                        if (w[28 + FLAG_ARR]) begin
                            phase_next = PH_ICNT;
                        end else if (w[28 + FLAG_INT]) begin
                            phase_next = PH_PARAM;
                        end else if (w[28 + FLAG_EXT]) begin
                            phase_next = PH_PARAM;
                            elem_next  = 32'd2;
                        end else if (w[28 + FLAG_STR]) begin
                            phase_next = PH_SLEN;
                        end else begin
                            res.frame_end = 1'b1;
                        end
                    end
                    PH_PARAM: begin
                        res.kind  = KIND_PARAM;
                        res.index = {30'd0, pidx};
                        if (pidx == 2'd0 || pidx == 2'd2) begin
                            elem_next = {30'd0, pidx + 2'd1};
                        end else if (pidx == 2'd1 && flags_reg[FLAG_EXT]) begin
                            elem_next = 32'd2;
                        end else begin
                            elem_next = '0;
                            if (flags_reg[FLAG_STR]) begin
                                phase_next = PH_SLEN;
                            end else begin
                                res.frame_end = 1'b1;
                                phase_next    = PH_CMD;
                                boff_next     = '0;
                            end
                        end
                    end
                    PH_SLEN: begin
                        res.kind   = KIND_SLEN;
                        bytes_next = w;
                        boff_next  = '0;
                        if (w == 32'd0) begin
                            res.frame_end = 1'b1;
                            phase_next    = PH_CMD;
                            elem_next     = '0;
                        end else begin
                            phase_next = PH_SBYTE;
                        end
                    end
                    PH_ICNT: begin
                        res.kind   = KIND_ICNT;
                        ints_next  = w;
                        phase_next = PH_SCNT;
                    end
                    PH_SCNT: begin
                        res.kind  = KIND_SCNT;
                        strs_next = w;
                        elem_next = '0;
                        if (ints_reg != 32'd0) begin
                            phase_next = PH_AINT;
                        end else if (w != 32'd0) begin
                            phase_next = PH_ASLEN;
                        end else begin
                            res.frame_end = 1'b1;
                            phase_next    = PH_CMD;
                            boff_next     = '0;
                        end
                    end
                    PH_AINT: begin
                        res.kind  = KIND_AINT;
                        res.index = elem_reg;
                        elem_next = elem_reg + 32'd1;
                        ints_next = (ints_reg != 32'd0) ? ints_reg - 32'd1 : 32'd0;
                        if (ints_reg <= 32'd1) begin
                            if (strs_reg != 32'd0) begin
                                phase_next = PH_ASLEN;
                                elem_next  = '0;
                            end else begin
                                res.frame_end = 1'b1;
                                phase_next    = PH_CMD;
                                elem_next     = '0;
                                boff_next     = '0;
                            end
                        end
                    end
                    PH_ASLEN: begin
                        res.kind   = KIND_ASLEN;
                        res.index  = elem_reg;
                        bytes_next = w;
                        boff_next  = '0;
                        if (w != 32'd0) begin
                            phase_next = PH_ASBYTE;
                        end else begin
                            strs_next = sdec;
                            if (sdec == 32'd0) begin
                                res.frame_end = 1'b1;
                                phase_next    = PH_CMD;
                                elem_next     = '0;
                            end else begin
                                elem_next = elem_reg + 32'd1;
                            end
                        end
                    end
                    default: begin
                        // unused phase code: back to reset state
                        res_valid  = 1'b0;
                        phase_next = PH_CMD;
                        flags_next = '0;
                        ints_next  = '0;
                        strs_next  = '0;
                        bytes_next = '0;
                        elem_next  = '0;
                        boff_next  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CMD;
            bpos_reg  <= '0;
            shift_reg <= '0;
            flags_reg <= '0;
            ints_reg  <= '0;
            strs_reg  <= '0;
            bytes_reg <= '0;
            elem_reg  <= '0;
            boff_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            bpos_reg  <= bpos_next;
            shift_reg <= shift_next;
            flags_reg <= flags_next;
            ints_reg  <= ints_next;
            strs_reg  <= strs_next;
            bytes_reg <= bytes_next;
            elem_reg  <= elem_next;
            boff_reg  <= boff_next;
        end
    end

endmodule

// File: rtl/core/fbfp_queue.sv
// ----------------------------------------------------------------------------
// fbfp_queue
// Two-entry result queue between the parser and the output port.
// ----------------------------------------------------------------------------
module fbfp_queue
    import fbfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    full,
    output logic    rd_valid,
    output result_t rd_data,
    input  logic    rd_en
);

    result_t    mem_reg [QUEUE_DEPTH];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (wr_en) wptr_reg <= ~wptr_reg;
            if (rd_en) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

// File: rtl/core/flagged_binary_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// flagged_binary_frame_parser_unit
// Splits a byte stream of flagged binary frames into tagged results.
// ----------------------------------------------------------------------------
// s_axis carries one stream byte per item. m_axis carries one result item
// for each completed 32-bit word or payload byte; bytes inside a word give
// no result. m_axis_tlast marks the result that completes a frame.
// Throughput is one byte per cycle while the result queue is not full. A
// result is worked out by the parser in the same cycle as the byte that
// completes it is accepted, and is registered in the two-entry result
// queue before it appears on m_axis.
// When the receiver stalls, results fill the queue and s_axis_tready drops
// once the queue is full; no byte or result is lost.
// Reset (aresetn low, synchronous) returns the parser to waiting for a
// command word and empties the queue.
// ----------------------------------------------------------------------------
module flagged_binary_frame_parser_unit
    import fbfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] value, [63:32] index
    output logic [3:0]  m_axis_tuser,   // [3:0] kind
    output logic        m_axis_tlast
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    logic    q_full;
    result_t q_data;

    // a byte gives at most one result, so a free slot is enough
    assign s_axis_tready = ~q_full;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    fbfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (in_fire),
        .byte_data  (s_axis_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    fbfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res),
        .full     (q_full),
        .rd_valid (m_axis_tvalid),
        .rd_data  (q_data),
        .rd_en    (m_axis_tvalid & m_axis_tready)
    );

    assign m_axis_tdata = {q_data.index, q_data.value};
    assign m_axis_tuser = q_data.kind;
    assign m_axis_tlast = q_data.frame_end;

endmodule
